>>> rtl/radial_frequency_bin_filter_macros.svh
// ----------------------------------------------------------------------------
// Radial frequency-bin filter assertion macros
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// They compile away to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RADIAL_FREQUENCY_BIN_FILTER_MACROS_SVH
`define RADIAL_FREQUENCY_BIN_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside reset.
`define RFBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the same edge.
`define RFBF_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`else

`define RFBF_ASSERT(lbl, prop, msg)
`define RFBF_ASSERT_IMPL(lbl, pre, post, msg)

`endif

`endif

>>> rtl/rfbf_pkg.sv
// ----------------------------------------------------------------------------
// Radial frequency-bin filter package
// Field widths, request types, register codes and the constant exp table.
// ----------------------------------------------------------------------------
`default_nettype none

package rfbf_pkg;

  localparam int unsigned IDX_W          = 8;
  localparam int unsigned SIDE_W         = 9;
  localparam int unsigned MAX_SIDE       = 256;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned PARTS          = 2;
  localparam int unsigned GAIN_FRAC_BITS = 24;
  localparam int unsigned GAIN_W         = 32;
  localparam int unsigned RATE_W         = 32;
  localparam int unsigned CUTOFF_W       = 21;
  localparam int unsigned SQ4_W          = 18;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic MODE_LOWPASS = 1'b0;
  localparam logic MODE_GAUSS   = 1'b1;

  // exp table: 2^(-j/depth) in Q30
  localparam int unsigned EXP_TABLE_DEPTH = 256;
  localparam int unsigned TAB_BITS        = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned TAB_W           = 31;
  localparam int unsigned WEIGHT_FRAC     = 30;
  localparam int unsigned SERIES_TERMS    = 20;
  localparam logic [63:0] ONE_Q30         = 64'd1 << WEIGHT_FRAC;
  localparam logic [63:0] LN2_Q30         = 64'd744261118;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X      = 3'd0,
    REG_SIZE_Y      = 3'd1,
    REG_SIZE_Z      = 3'd2,
    REG_FILTER_MODE = 3'd3,
    REG_CUTOFF_SQ4  = 3'd4,
    REG_GAUSS_RATE  = 3'd5,
    REG_GAUSS_PEAK  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_PASS  = 2'd0,
    CLS_ZERO  = 2'd1,
    CLS_GAUSS = 2'd2
  } bin_class_e;

  typedef struct packed {
    logic [SIDE_W-1:0]   size_x;
    logic [SIDE_W-1:0]   size_y;
    logic [SIDE_W-1:0]   size_z;
    logic                filter_mode;
    logic [CUTOFF_W-1:0] cutoff_sq4;
    logic [RATE_W-1:0]   gauss_rate;
    logic [GAIN_W-1:0]   gauss_peak;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    size_x:      9'd256,
    size_y:      9'd256,
    size_z:      9'd256,
    filter_mode: MODE_LOWPASS,
    cutoff_sq4:  21'd0,
    gauss_rate:  32'd0,
    gauss_peak:  32'd16777216
  };

  typedef struct packed {
    logic [IDX_W-1:0]           x_index;
    logic [IDX_W-1:0]           y_index;
    logic [IDX_W-1:0]           z_index;
    logic signed [SAMPLE_W-1:0] bin_real;
    logic signed [SAMPLE_W-1:0] bin_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_real;
    logic signed [SAMPLE_W-1:0] out_imag;
    logic                       saturated;
  } out_item_t;

  // classified request between front and back
  typedef struct packed {
    bin_class_e                         cls;
    logic [SQ4_W-1:0]                   sq4;
    logic [PARTS-1:0][SAMPLE_W-1:0]     bin;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [TAB_W-1:0] exp_word_t;
  typedef exp_word_t [EXP_TABLE_DEPTH-1:0] exp_tab_t;

  // alternating Taylor series of exp(-j ln2 / depth), truncated per term
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] negs;
    for (int J = 0; J < EXP_TABLE_DEPTH; J++) begin
      s    = (64'(J) * LN2_Q30) / EXP_TABLE_DEPTH;
      t    = ONE_Q30;
      pos  = ONE_Q30;
      negs = 64'd0;
      for (int Nt = 1; Nt <= SERIES_TERMS; Nt++) begin
        t = ((t * s) >> WEIGHT_FRAC) / 64'(Nt);
        if (Nt % 2 == 1) begin
          negs = negs + t;
        end else begin
          pos = pos + t;
        end
      end
      tab[J] = TAB_W'(pos - negs);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

>>> rtl/radial_frequency_bin_filter.sv
// ----------------------------------------------------------------------------
// Radial frequency-bin filter
// Ideal low-pass or Gaussian weighting of complex 3D FFT bins by radius.
//
// Channel  Dir  Handshake                  Payload
// config   in   cfg_we_i                   cfg_index_i, cfg_wdata_i
// bin      in   in_valid_i / in_ready_o    in_item_i
// result   out  out_valid_o / out_ready_i  out_item_o
//
// Sustains one bin per cycle while results are taken; each request passes
// through six front stages, one queue slot and eight back stages.
// Reset loads the register defaults; there is no clearing pass.
// A stalled result freezes the back end only; the front keeps accepting until
// the queue holds QUEUE_DEPTH requests and the last front stage holds one more.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radial_frequency_bin_filter_macros.svh"

module radial_frequency_bin_filter #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rfbf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rfbf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rfbf_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rfbf_pkg::out_item_t                 out_item_o
);
  import rfbf_pkg::*;

  cfg_t      cfg_q;
  logic      push, pop;
  q_entry_t  push_entry, pop_entry;
  q_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SIZE_X:      cfg_q.size_x      <= cfg_wdata_i[SIDE_W-1:0];
        REG_SIZE_Y:      cfg_q.size_y      <= cfg_wdata_i[SIDE_W-1:0];
        REG_SIZE_Z:      cfg_q.size_z      <= cfg_wdata_i[SIDE_W-1:0];
        REG_FILTER_MODE: cfg_q.filter_mode <= cfg_wdata_i[0];
        REG_CUTOFF_SQ4:  cfg_q.cutoff_sq4  <= cfg_wdata_i[CUTOFF_W-1:0];
        REG_GAUSS_RATE:  cfg_q.gauss_rate  <= cfg_wdata_i[RATE_W-1:0];
        REG_GAUSS_PEAK:  cfg_q.gauss_peak  <= cfg_wdata_i[GAIN_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  rfbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .q_status_i (q_status)
  );

  rfbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  rfbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .entry_i     (pop_entry),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `RFBF_ASSERT_IMPL(a_front_stall_on_full, !in_ready_o, q_status.full, "front stalled with room in queue")
  `RFBF_ASSERT_IMPL(a_lowpass_no_sat, out_valid_o && (cfg_q.filter_mode != MODE_GAUSS), !out_item_o.saturated, "saturation flagged in low-pass mode")
  `RFBF_ASSERT_IMPL(a_zero_peak_zero_out, out_valid_o && (cfg_q.filter_mode == MODE_GAUSS) && (cfg_q.gauss_peak == '0), (out_item_o.out_real == '0) && (out_item_o.out_imag == '0) && !out_item_o.saturated, "nonzero result with zero Gaussian peak")

endmodule

`default_nettype wire

>>> rtl/rfbf_front.sv
// ----------------------------------------------------------------------------
// Radial frequency-bin filter front end
// Accepts bins, centres the indices, forms four times the squared radius and
// classifies each request as pass, zero or Gaussian before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfbf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfbf_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rfbf_pkg::in_item_t  in_item_i,
  output logic                push_o,
  output rfbf_pkg::q_entry_t  entry_o,
  input  rfbf_pkg::q_status_t q_status_i
);
  import rfbf_pkg::*;

  localparam int unsigned AXES            = 3;
  localparam int unsigned V_W             = SIDE_W;
  localparam int unsigned MOD_STEPS       = SIDE_W;
  localparam int unsigned MOD_STAGES      = 3;
  localparam int unsigned STEPS_PER_STAGE = MOD_STEPS / MOD_STAGES;
  localparam int unsigned SH_W            = SIDE_W + MOD_STEPS;
  localparam int unsigned D_W             = SIDE_W + 2;
  localparam int unsigned SQ_W            = SQ4_W - 1;
  localparam int unsigned LAST            = MOD_STAGES + 2;

  typedef logic [AXES-1:0][V_W-1:0] axis_rem_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    if (s == '0) begin
      return SIDE_W'(1);
    end else if (s > SIDE_W'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end else begin
      return s;
    end
  endfunction

  // one restoring step of the remainder by n << k
  function automatic logic [V_W-1:0] mod_step(input logic [V_W-1:0]    v,
                                              input logic [SIDE_W-1:0] n,
                                              input int unsigned       k);
    logic [SH_W-1:0] sh;
    sh = SH_W'(n) << k;
    if (sh <= SH_W'(v)) begin
      return v - sh[V_W-1:0];
    end else begin
      return v;
    end
  endfunction

  logic [AXES-1:0][SIDE_W-1:0]    side;
  logic [AXES-1:0][IDX_W-1:0]     idx;
  logic [LAST:0]                  vld_q;
  logic                           adv;
  axis_rem_t                      rem_q [MOD_STAGES+1];
  axis_rem_t                      rem_d [MOD_STAGES+1];
  logic [AXES-1:0][SQ_W-1:0]      sq_q, sq_d;
  logic [LAST-1:0][PARTS-1:0][SAMPLE_W-1:0] bin_q;
  logic [PARTS-1:0][SAMPLE_W-1:0] in_bin;
  q_entry_t                       entry_q, entry_d;
  logic [SQ4_W-1:0]               sq4;

  assign side[0] = clamp_side(cfg_i.size_x);
  assign side[1] = clamp_side(cfg_i.size_y);
  assign side[2] = clamp_side(cfg_i.size_z);
  assign idx     = {in_item_i.z_index, in_item_i.y_index, in_item_i.x_index};
  assign in_bin  = {in_item_i.bin_imag, in_item_i.bin_real};

  // hold every stage while the last one waits on a full queue
  assign adv        = !vld_q[LAST] || !q_status_i.full;
  assign in_ready_o = adv;
  assign push_o     = vld_q[LAST] && !q_status_i.full;
  assign entry_o    = entry_q;

  always_comb begin
    logic [V_W-1:0] v;
    v = '0;
    for (int a = 0; a < AXES; a++) begin
      rem_d[0][a] = V_W'(idx[a]) + V_W'(side[a] >> 1);
    end
    for (int s = 0; s < MOD_STAGES; s++) begin
      for (int a = 0; a < AXES; a++) begin
        v = rem_q[s][a];
        for (int t = 0; t < STEPS_PER_STAGE; t++) begin
          v = mod_step(v, side[a], MOD_STEPS - 1 - s * STEPS_PER_STAGE - t);
        end
        rem_d[s+1][a] = v;
      end
    end
  end

  always_comb begin
    logic signed [D_W-1:0]     d;
    logic signed [2*D_W-1:0]   p;
    d = '0;
    p = '0;
    for (int a = 0; a < AXES; a++) begin
      d = $signed({1'b0, rem_q[MOD_STAGES][a], 1'b0}) - $signed({2'b00, side[a]});
      p = d * d;
      sq_d[a] = SQ_W'(p);
    end
  end

  assign sq4 = SQ4_W'(sq_q[0]) + SQ4_W'(sq_q[1]) + SQ4_W'(sq_q[2]);

  always_comb begin
    entry_d.sq4 = sq4;
    entry_d.bin = bin_q[LAST-1];
    if (cfg_i.filter_mode == MODE_GAUSS) begin
      entry_d.cls = CLS_GAUSS;
    end else if (sq4 > cfg_i.cutoff_sq4) begin
      entry_d.cls = CLS_ZERO;
    end else begin
      entry_d.cls = CLS_PASS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q   <= rem_d;
      sq_q    <= sq_d;
      bin_q   <= {bin_q[LAST-2:0], in_bin};
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rfbf_queue.sv
// ----------------------------------------------------------------------------
// Radial frequency-bin filter request queue
// Short first-in first-out queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rfbf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rfbf_pkg::q_entry_t  entry_i,
  input  logic                pop_i,
  output rfbf_pkg::q_entry_t  entry_o,
  output rfbf_pkg::q_status_t status_o
);
  import rfbf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  q_entry_t         slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign entry_o         = slot_q[rd_ptr_q];
  assign status_o.full   = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty  = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rfbf_back.sv
// ----------------------------------------------------------------------------
// Radial frequency-bin filter back end
// Eight-stage datapath: Gaussian weight from the exp table, gain, scaling of
// both parts with rounding, and saturation into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfbf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfbf_pkg::cfg_t      cfg_i,
  input  rfbf_pkg::q_entry_t  entry_i,
  input  rfbf_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rfbf_pkg::out_item_t out_item_o
);
  import rfbf_pkg::*;

  localparam int unsigned NSTG             = 8;
  localparam int unsigned A_W              = SQ4_W + RATE_W;
  localparam int unsigned A_LO_W           = GAIN_FRAC_BITS + 5;
  localparam int unsigned LOG2E_W          = 27;
  localparam int unsigned LOG2E_SHIFT      = 26;
  localparam int unsigned YP_W             = A_LO_W + LOG2E_W;
  localparam int unsigned Y_W              = YP_W - LOG2E_SHIFT;
  localparam int unsigned SH_W             = Y_W - GAIN_FRAC_BITS;
  localparam int unsigned WEIGHT_SHIFT_MAX = 31;
  localparam int unsigned GP_W             = GAIN_W + TAB_W;
  localparam int unsigned PROD_W           = SAMPLE_W + GAIN_W;
  localparam int unsigned Q_W              = PROD_W - GAIN_FRAC_BITS;

  localparam logic [A_W-1:0]     EXP_LIMIT = A_W'(32) << GAIN_FRAC_BITS;
  localparam logic [LOG2E_W-1:0] LOG2E_Q26 = 27'd96817625;
  localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [PROD_W-1:0]  ROUND     = PROD_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [Q_W-1:0]     LIM_NEG   = Q_W'(1) << (SAMPLE_W - 1);
  localparam logic [Q_W-1:0]     LIM_POS   = LIM_NEG - 1'b1;

  typedef struct packed {
    logic                sat;
    logic [SAMPLE_W-1:0] val;
  } part_t;

  function automatic part_t clip_part(input logic [Q_W-1:0] q, input logic neg);
    logic [Q_W-1:0]      lim;
    logic [SAMPLE_W-1:0] mag;
    part_t               r;
    lim   = neg ? LIM_NEG : LIM_POS;
    r.sat = (q > lim);
    mag   = r.sat ? lim[SAMPLE_W-1:0] : q[SAMPLE_W-1:0];
    r.val = neg ? (~mag + 1'b1) : mag;
    return r;
  endfunction

  logic [NSTG-1:0]                 vld_q;
  logic                            adv;
  bin_class_e [3:0]                cls_q;
  logic [2:0][PARTS-1:0][SAMPLE_W-1:0] bin_q;
  logic [3:0][PARTS-1:0]           neg_q;
  logic [A_W-1:0]                  a1_q;
  logic [Y_W-1:0]                  y2_q;
  logic                            big2_q;
  logic [TAB_W-1:0]                wraw3_q;
  logic [SH_W-1:0]                 sh3_q;
  logic                            kill3_q;
  logic [TAB_W-1:0]                w4_q;
  logic [PARTS-1:0][SAMPLE_W-1:0]  mag4_q, mag5_q;
  logic [GAIN_W-1:0]               gain5_q, gain_d;
  logic [PARTS-1:0][PROD_W-1:0]    prod6_q;
  logic [PARTS-1:0][Q_W-1:0]       q7_q;
  out_item_t                       out_q, out_d;
  logic [YP_W-1:0]                 yprod;
  logic [GP_W-1:0]                 gprod;
  logic [PARTS-1:0][SAMPLE_W-1:0]  mag_d;
  logic [PARTS-1:0]                neg_d;
  part_t [PARTS-1:0]               clip;

  // freeze the whole pipeline while a result waits
  assign adv         = !vld_q[NSTG-1] || out_ready_i;
  assign pop_o       = adv && !q_status_i.empty;
  assign out_valid_o = vld_q[NSTG-1];
  assign out_item_o  = out_q;

  assign yprod = YP_W'(a1_q[A_LO_W-1:0]) * YP_W'(LOG2E_Q26);
  assign gprod = GP_W'(cfg_i.gauss_peak) * GP_W'(w4_q);

  always_comb begin
    for (int p = 0; p < PARTS; p++) begin
      neg_d[p] = bin_q[2][p][SAMPLE_W-1];
      mag_d[p] = neg_d[p] ? (~bin_q[2][p] + 1'b1) : bin_q[2][p];
    end
  end

  // pass and zero requests reuse the scaler at unity and nil gain
  always_comb begin
    unique case (cls_q[3])
      CLS_PASS:  gain_d = GAIN_ONE;
      CLS_ZERO:  gain_d = '0;
      CLS_GAUSS: gain_d = gprod[WEIGHT_FRAC +: GAIN_W];
      default:   gain_d = '0;
    endcase
  end

  always_comb begin
    for (int p = 0; p < PARTS; p++) begin
      clip[p] = clip_part(q7_q[p], neg_q[3][p]);
    end
    out_d.out_real  = clip[0].val;
    out_d.out_imag  = clip[1].val;
    out_d.saturated = clip[0].sat || clip[1].sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], !q_status_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: exponent
      a1_q     <= A_W'(entry_i.sq4) * A_W'(cfg_i.gauss_rate);
      cls_q[0] <= entry_i.cls;
      bin_q[0] <= entry_i.bin;
      // stage 2: change to base 2
      big2_q   <= (a1_q >= EXP_LIMIT);
      y2_q     <= yprod[LOG2E_SHIFT +: Y_W];
      cls_q[1] <= cls_q[0];
      bin_q[1] <= bin_q[0];
      // stage 3: table lookup on the fraction
      wraw3_q  <= EXP_TAB[y2_q[GAIN_FRAC_BITS-1 -: TAB_BITS]];
      sh3_q    <= y2_q[Y_W-1:GAIN_FRAC_BITS];
      kill3_q  <= big2_q || (y2_q[Y_W-1:GAIN_FRAC_BITS] >= SH_W'(WEIGHT_SHIFT_MAX));
      cls_q[2] <= cls_q[1];
      bin_q[2] <= bin_q[1];
      // stage 4: integer part as a shift; split sign and magnitude
      w4_q     <= kill3_q ? '0 : (wraw3_q >> sh3_q);
      cls_q[3] <= cls_q[2];
      mag4_q   <= mag_d;
      neg_q[0] <= neg_d;
      // stage 5: gain
      gain5_q  <= gain_d;
      mag5_q   <= mag4_q;
      neg_q[1] <= neg_q[0];
      // stage 6: scale both parts
      for (int p = 0; p < PARTS; p++) begin
        prod6_q[p] <= PROD_W'(mag5_q[p]) * PROD_W'(gain5_q);
      end
      neg_q[2] <= neg_q[1];
      // stage 7: round to nearest, ties away from zero
      for (int p = 0; p < PARTS; p++) begin
        q7_q[p] <= Q_W'((prod6_q[p] + ROUND) >> GAIN_FRAC_BITS);
      end
      neg_q[3] <= neg_q[2];
      // stage 8: saturate and restore sign
      out_q    <= out_d;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial frequency-bin filter testbench
// Drives complex bins through the filter under random input gaps and output
// stalls, predicts every filtered bin from a local copy of the registers and
// compares each result field by field, in order, with the predicted bins.
// ----------------------------------------------------------------------------
module tb_top;
  import rfbf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_BINS   = 100;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic [31:0] GAIN_ONE   = 32'h0100_0000;
  localparam logic [31:0] GAIN_HALF  = 32'h0080_0000;
  localparam logic [31:0] GAIN_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] RATE_EDGE  = 32'h0800_0000;
  localparam logic [31:0] CUTOFF_MAX = 32'h001F_FFFF;
  localparam logic [31:0] S_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN      = 32'h8000_0000;

  localparam logic [63:0] LN2_FIX30    = 64'd744261118;
  localparam logic [63:0] LOG2E_FIX26  = 64'd96817625;
  localparam logic [63:0] EXPO_CEILING = 64'd32 << GAIN_FRAC_BITS;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;

  cfg_t        bin_cfg;
  logic [63:0] pow2_tab [EXP_TABLE_DEPTH];
  out_item_t   expected_bins [$];
  int          fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          src_gaps    = 1'b0;
  bit          sink_stalls = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned hold_len    = 0;

  radial_frequency_bin_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // 2^(-k/depth) in Q30 from the truncated alternating series
  task automatic build_pow2_table();
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] even_sum;
    logic [63:0] odd_sum;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      s        = (64'(k) * LN2_FIX30) / EXP_TABLE_DEPTH;
      t        = 64'd1 << 30;
      even_sum = t;
      odd_sum  = '0;
      for (int n = 1; n <= 20; n++) begin
        t = ((t * s) >> 30) / 64'(n);
        if (n % 2 == 1) begin
          odd_sum = odd_sum + t;
        end else begin
          even_sum = even_sum + t;
        end
      end
      pow2_tab[k] = even_sum - odd_sum;
    end
  endtask

  function automatic logic [63:0] axis_dist_sq(input logic [IDX_W-1:0] m,
                                               input logic [SIDE_W-1:0] side);
    int n;
    int i;
    int d;
    n = (side == 0) ? 1 : ((side > MAX_SIDE) ? MAX_SIDE : int'(side));
    i = (int'(m) + n / 2) % n;
    d = 2 * i - n;
    return 64'(d * d);
  endfunction

  function automatic logic [63:0] gauss_weight(input logic [63:0] expo);
    logic [63:0] y;
    logic [63:0] n;
    logic [63:0] j;
    if (expo >= EXPO_CEILING) return '0;
    y = (expo * LOG2E_FIX26) >> 26;
    n = y >> GAIN_FRAC_BITS;
    j = ((y & ((64'd1 << GAIN_FRAC_BITS) - 1)) * EXP_TABLE_DEPTH) >> GAIN_FRAC_BITS;
    if (n >= 31) return '0;
    return pow2_tab[j] >> n;
  endfunction

  // {clipped, scaled part}: round half away from zero, then saturate
  function automatic logic [32:0] scale_part(input logic [31:0] x, input logic [63:0] gain);
    logic        neg;
    logic [31:0] m32;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] q;
    logic [63:0] lim;
    logic        clip;
    neg  = x[31];
    m32  = neg ? (~x + 32'd1) : x;
    lo   = 64'(m32[23:0]) * gain;
    hi   = 64'(m32[31:24]) * gain;
    q    = hi + ((lo + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS);
    lim  = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
    clip = 1'b0;
    if (q > lim) begin
      q    = lim;
      clip = 1'b1;
    end
    return {clip, neg ? (~q[31:0] + 32'd1) : q[31:0]};
  endfunction

  function automatic out_item_t filter_bin(input in_item_t b);
    out_item_t   r;
    logic [63:0] sq4;
    logic [63:0] gain;
    logic [32:0] part_re;
    logic [32:0] part_im;
    sq4 = axis_dist_sq(b.x_index, bin_cfg.size_x) + axis_dist_sq(b.y_index, bin_cfg.size_y)
        + axis_dist_sq(b.z_index, bin_cfg.size_z);
    if (bin_cfg.filter_mode == MODE_LOWPASS) begin
      r.saturated = 1'b0;
      if (sq4 > 64'(bin_cfg.cutoff_sq4)) begin
        r.out_real = '0;
        r.out_imag = '0;
      end else begin
        r.out_real = b.bin_real;
        r.out_imag = b.bin_imag;
      end
    end else begin
      gain = (64'(bin_cfg.gauss_peak) * gauss_weight(sq4 * 64'(bin_cfg.gauss_rate))) >> 30;
      part_re     = scale_part(b.bin_real, gain);
      part_im     = scale_part(b.bin_imag, gain);
      r.out_real  = part_re[31:0];
      r.out_imag  = part_im[31:0];
      r.saturated = part_re[32] | part_im[32];
    end
    return r;
  endfunction

  function automatic in_item_t bin_of(input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] z, input logic [31:0] re,
                                      input logic [31:0] im);
    in_item_t b;
    b.x_index  = x;
    b.y_index  = y;
    b.z_index  = z;
    b.bin_real = re;
    b.bin_imag = im;
    return b;
  endfunction

  function automatic logic [31:0] random_sample();
    logic [31:0] v;
    v = $urandom >> $urandom_range(4, 31);
    case ($urandom_range(0, 7))
      0:       return S_MIN;
      1:       return S_MAX;
      2, 3:    return $urandom;
      default: return ($urandom_range(0, 1) == 1) ? (~v + 32'd1) : v;
    endcase
  endfunction

  function automatic in_item_t random_bin();
    return bin_of(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), random_sample(), random_sample());
  endfunction

  function automatic logic [31:0] random_side();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd511;
      2:       return 32'd256;
      3:       return 32'd1;
      default: return $urandom_range(2, 300);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SIZE_X:      bin_cfg.size_x      = data[SIDE_W-1:0];
      REG_SIZE_Y:      bin_cfg.size_y      = data[SIDE_W-1:0];
      REG_SIZE_Z:      bin_cfg.size_z      = data[SIDE_W-1:0];
      REG_FILTER_MODE: bin_cfg.filter_mode = data[0];
      REG_CUTOFF_SQ4:  bin_cfg.cutoff_sq4  = data[CUTOFF_W-1:0];
      REG_GAUSS_RATE:  bin_cfg.gauss_rate  = data;
      REG_GAUSS_PEAK:  bin_cfg.gauss_peak  = data;
      default: ;
    endcase
  endtask

  task automatic send_bin(input in_item_t b);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_bins.push_back(filter_bin(b));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_bins.size() != 0);
  endtask

  task automatic set_all_regs(input logic [31:0] sx, input logic [31:0] sy,
                              input logic [31:0] sz, input logic mode,
                              input logic [31:0] cutoff, input logic [31:0] rate,
                              input logic [31:0] peak);
    wait_results_drained();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_FILTER_MODE, 32'(mode));
    write_reg(REG_CUTOFF_SQ4, cutoff);
    write_reg(REG_GAUSS_RATE, rate);
    write_reg(REG_GAUSS_PEAK, peak);
  endtask

  // Reset state: cutoff 0, so only the centre bin passes, on the boundary
  task automatic test_lowpass_reset_state();
    send_bin(bin_of(8'd0, 8'd0, 8'd0, S_MAX, S_MIN));
    send_bin(bin_of(8'd0, 8'd0, 8'd1, 32'd1, 32'hFFFF_FFFF));
    send_bin(bin_of(8'd128, 8'd128, 8'd128, S_MIN, S_MAX));
    send_bin(bin_of(8'd255, 8'd255, 8'd255, S_MAX, S_MAX));
  endtask

  task automatic test_size_and_cutoff_corners();
    // zero size, oversized side, index beyond the side, widest cutoff
    set_all_regs(32'd0, 32'd511, 32'd5, MODE_LOWPASS, CUTOFF_MAX, 32'd0, GAIN_ONE);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_bin(bin_of(8'd255, 8'd255, 8'd255, S_MIN, 32'd12345));
    send_bin(bin_of(8'd4, 8'd5, 8'd6, 32'hFFFF_0000, S_MAX));
    set_all_regs(32'd256, 32'd256, 32'd256, MODE_LOWPASS, 32'd4, 32'd0, GAIN_ONE);
    send_bin(bin_of(8'd0, 8'd0, 8'd1, S_MAX, S_MIN));
    send_bin(bin_of(8'd0, 8'd1, 8'd1, S_MAX, S_MIN));
  endtask

  task automatic test_gaussian_corners();
    set_all_regs(32'd256, 32'd256, 32'd256, MODE_GAUSS, 32'd0, 32'd0, GAIN_ONE);
    send_bin(bin_of(8'd5, 8'd6, 8'd7, S_MAX, S_MIN));
    wait_results_drained();
    write_reg(REG_GAUSS_PEAK, GAIN_MAX);
    send_bin(bin_of(8'd0, 8'd0, 8'd0, S_MAX, S_MIN));
    send_bin(bin_of(8'd0, 8'd0, 8'd0, 32'd0, 32'd1));
    // exact halves round away from zero
    wait_results_drained();
    write_reg(REG_GAUSS_PEAK, GAIN_HALF);
    send_bin(bin_of(8'd0, 8'd0, 8'd0, 32'd1, 32'hFFFF_FFFF));
    send_bin(bin_of(8'd0, 8'd0, 8'd0, 32'd3, 32'hFFFF_FFFD));
    wait_results_drained();
    write_reg(REG_GAUSS_PEAK, 32'd0);
    send_bin(bin_of(8'd0, 8'd0, 8'd0, 32'd123456, 32'hFFFE_1DC0));
    set_all_regs(32'd256, 32'd256, 32'd256, MODE_GAUSS, 32'd0, GAIN_MAX, GAIN_ONE);
    send_bin(bin_of(8'd0, 8'd0, 8'd1, S_MAX, S_MIN));
    send_bin(bin_of(8'd0, 8'd0, 8'd0, S_MAX, S_MIN));
    // exponent just below and at the exp limit, at and above which the weight is forced to zero
    wait_results_drained();
    write_reg(REG_GAUSS_RATE, RATE_EDGE - 32'd1);
    send_bin(bin_of(8'd0, 8'd0, 8'd1, S_MAX, S_MIN));
    wait_results_drained();
    write_reg(REG_GAUSS_RATE, RATE_EDGE);
    send_bin(bin_of(8'd0, 8'd0, 8'd1, S_MAX, S_MIN));
  endtask

  task automatic run_random_phase(input int n_bins, input logic mode);
    logic [31:0] cutoff;
    logic [31:0] rate;
    cutoff = ($urandom_range(0, 7) == 0) ? CUTOFF_MAX : $urandom_range(0, 196608);
    rate   = ($urandom_range(0, 7) == 0) ? $urandom : ($urandom >> $urandom_range(10, 31));
    set_all_regs(random_side(), random_side(), random_side(), mode, cutoff, rate,
                 $urandom >> $urandom_range(0, 31));
    repeat (n_bins) send_bin(random_bin());
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      src_gaps    = (p != 2);
      sink_stalls = (p != 2);
      run_random_phase(PHASE_BINS, (p % 2 == 1) ? MODE_GAUSS : MODE_LOWPASS);
    end
  endtask

  // Hold the output off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    src_gaps    = 1'b0;
    sink_stalls = 1'b1;
    wait_results_drained();
    hold_len = 250;
    hold_req = 1'b1;
    repeat (60) send_bin(random_bin());
    wait_results_drained();
    repeat (20) send_bin(random_bin());
  endtask

  task automatic test_streaming_tail();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    run_random_phase(PHASE_BINS, MODE_GAUSS);
    run_random_phase(PHASE_BINS / 2, MODE_LOWPASS);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bins.size() == 0) begin
        $error("result with no request outstanding: out_real %0d out_imag %0d",
               out_item_o.out_real, out_item_o.out_imag);
        fail_count++;
      end else begin
        want = expected_bins.pop_front();
        if (out_item_o.out_real !== want.out_real) begin
          $error("out_real: expected %0d, got %0d", want.out_real, out_item_o.out_real);
          fail_count++;
        end
        if (out_item_o.out_imag !== want.out_imag) begin
          $error("out_imag: expected %0d, got %0d", want.out_imag, out_item_o.out_imag);
          fail_count++;
        end
        if (out_item_o.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_item_o.saturated);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    build_pow2_table();
    bin_cfg.size_x      = 9'd256;
    bin_cfg.size_y      = 9'd256;
    bin_cfg.size_z      = 9'd256;
    bin_cfg.filter_mode = MODE_LOWPASS;
    bin_cfg.cutoff_sq4  = '0;
    bin_cfg.gauss_rate  = '0;
    bin_cfg.gauss_peak  = GAIN_ONE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lowpass_reset_state();
    test_size_and_cutoff_corners();
    test_gaussian_corners();
    test_random_traffic();
    test_output_backpressure();
    test_streaming_tail();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rfbf_pkg.sv
rtl/rfbf_front.sv
rtl/rfbf_queue.sv
rtl/rfbf_back.sv
rtl/radial_frequency_bin_filter.sv
tb/tb_top.sv
